// ===== hdl/aabb_collision_resolve_unit_macros.svh =====
// Assertion macros shared by the collision resolver RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef AABB_COLLISION_RESOLVE_UNIT_MACROS_SVH
`define AABB_COLLISION_RESOLVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ACR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ACR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/acr_pkg.sv =====
// Package of the box collision resolver: widths, codes and pipeline types.
// Depends on nothing; used by every module of the block.
package acr_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVER_INV_MASS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_INV_MASS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVER_RESTITUTION  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_RESTITUTION  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CORRECTION_SLOP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CORRECTION_PERCENT = 3'd5;

   localparam int MASS_W = 25;
   localparam int FRAC_W = 17;
   localparam int SUM_W  = 26;
   localparam int RFAC_W = 18;
   localparam int DD_W   = 31;
   localparam int NRV_W  = 33;
   localparam int T_W    = 32;
   localparam int K_W    = 34;
   localparam int QUO_W  = 34;
   localparam int NUM_W  = 60;
   localparam int DLT_W  = 36;

   localparam int REQ_TDATA_W = 384;
   localparam int RSP_TDATA_W = 264;

   localparam int DIV_STEP_BITS_DEF = 2;

   localparam logic [MASS_W-1:0] MOVER_INV_MASS_RST     = 25'd65536;
   localparam logic [MASS_W-1:0] BLOCK_INV_MASS_RST     = 25'd65536;
   localparam logic [FRAC_W-1:0] MOVER_RESTITUTION_RST  = 17'd0;
   localparam logic [FRAC_W-1:0] BLOCK_RESTITUTION_RST  = 17'd0;
   localparam logic [MASS_W-1:0] CORRECTION_SLOP_RST    = 25'd13107;
   localparam logic [FRAC_W-1:0] CORRECTION_PERCENT_RST = 17'd19661;
   localparam logic [RFAC_W-1:0] RFAC_ONE               = 18'd65536;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_UP    = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4
   } acr_dir_type;

   typedef struct packed {
      logic [MASS_W-1:0] mim;
      logic [MASS_W-1:0] bim;
      logic [SUM_W-1:0]  isum;
      logic [RFAC_W-1:0] rfac;
      logic [MASS_W-1:0] slop;
      logic [FRAC_W-1:0] pct;
   } acr_cfg_type;

   typedef struct packed {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mvx;
      logic signed [31:0] mvy;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bvx;
      logic signed [31:0] bvy;
   } acr_box_type;

   typedef struct packed {
      acr_box_type box;
      logic [30:0] mw;
      logic [30:0] mh;
      logic [30:0] bw;
      logic [30:0] bh;
   } acr_req_type;

   typedef struct packed {
      logic        hit;
      acr_dir_type dir;
      logic        fix;
      logic        yaxis;
      logic        neg;
   } acr_ctl_type;

   typedef struct packed {
      acr_box_type     box;
      acr_ctl_type     ctl;
      logic [T_W-1:0]  t;
      logic [K_W-1:0]  k;
   } acr_num_type;

   typedef struct packed {
      logic        hit;
      acr_dir_type dir;
      logic        on_block;
      acr_box_type box;
   } acr_rsp_type;

endpackage

// ===== hdl/acr_front.sv =====
// Front end of the resolver: overlap test, contact normal, depth and closing speed.
// Two register stages. Depends on acr_pkg.
module acr_front import acr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  acr_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  acr_req_type       in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output acr_box_type       out_box,
   output acr_ctl_type       out_ctl,
   output logic [DD_W-1:0]   out_dd,
   output logic [NRV_W-1:0]  out_nrv
);

   logic              a_v_ff, a_v_in, en_a;
   acr_box_type       a_box_ff;
   logic              a_hit_ff, a_hit_in;
   logic [30:0]       a_ovx_ff, a_ovx_in, a_ovy_ff, a_ovy_in;
   logic              a_xlt_ff, a_xlt_in, a_xgt_ff, a_xgt_in;
   logic              a_ylt_ff, a_ylt_in, a_ygt_ff, a_ygt_in;
   logic signed [32:0] a_dvx_ff, a_dvx_in, a_dvy_ff, a_dvy_in;

   logic              b_v_ff, b_v_in, en_b;
   acr_box_type       b_box_ff;
   acr_ctl_type       b_ctl_ff, b_ctl_in;
   logic [DD_W-1:0]   b_dd_ff, b_dd_in;
   logic [NRV_W-1:0]  b_nrv_ff, b_nrv_in;

   logic signed [33:0] mx_e, my_e, bx_e, by_e, mxr, myr, bxr, byr, ovx_w, ovy_w;
   logic [30:0]        depth;
   logic signed [31:0] ds;
   logic signed [32:0] dsel;
   logic signed [33:0] nrvs;

   assign en_b     = !b_v_ff || out_ready;
   assign en_a     = !a_v_ff || en_b;
   assign in_ready = en_a;
   assign a_v_in   = en_a ? in_valid : a_v_ff;
   assign b_v_in   = en_b ? a_v_ff : b_v_ff;

   // Stage A: edges, overlap test and per-axis overlap.
   always_comb begin
      mx_e = {{2{in_data.box.mx[31]}}, in_data.box.mx};
      my_e = {{2{in_data.box.my[31]}}, in_data.box.my};
      bx_e = {{2{in_data.box.bx[31]}}, in_data.box.bx};
      by_e = {{2{in_data.box.by[31]}}, in_data.box.by};
      mxr  = mx_e + $signed({3'b000, in_data.mw});
      myr  = my_e + $signed({3'b000, in_data.mh});
      bxr  = bx_e + $signed({3'b000, in_data.bw});
      byr  = by_e + $signed({3'b000, in_data.bh});
      a_hit_in = !((mx_e > bxr) || (mxr < bx_e) || (my_e > byr) || (myr < by_e));
      a_xlt_in = mx_e < bx_e;
      a_xgt_in = mx_e > bx_e;
      a_ylt_in = my_e < by_e;
      a_ygt_in = my_e > by_e;
      ovx_w = '0;
      if (a_xlt_in) ovx_w = mxr - bx_e;
      if (a_xgt_in) ovx_w = bxr - mx_e;
      ovy_w = '0;
      if (a_ylt_in) ovy_w = myr - by_e;
      if (a_ygt_in) ovy_w = byr - my_e;
      a_ovx_in = ovx_w[30:0];
      a_ovy_in = ovy_w[30:0];
      a_dvx_in = $signed({in_data.box.mvx[31], in_data.box.mvx})
               - $signed({in_data.box.bvx[31], in_data.box.bvx});
      a_dvy_in = $signed({in_data.box.mvy[31], in_data.box.mvy})
               - $signed({in_data.box.bvy[31], in_data.box.bvy});
   end

   // Stage B: normal choice, clamped depth beyond slop, closing speed.
   always_comb begin
      b_ctl_in.hit = a_hit_ff;
      b_ctl_in.dir = DIR_NONE;
      if (a_hit_ff) begin
         if (a_ovx_ff > a_ovy_ff && a_ygt_ff) b_ctl_in.dir = DIR_DOWN;
         else if (a_ovx_ff > a_ovy_ff && a_ylt_ff) b_ctl_in.dir = DIR_UP;
         else if (a_ovy_ff > a_ovx_ff && a_xlt_ff) b_ctl_in.dir = DIR_LEFT;
         else if (a_ovy_ff > a_ovx_ff && a_xgt_ff) b_ctl_in.dir = DIR_RIGHT;
      end
      b_ctl_in.yaxis = (b_ctl_in.dir == DIR_UP) || (b_ctl_in.dir == DIR_DOWN);
      b_ctl_in.neg   = (b_ctl_in.dir == DIR_UP) || (b_ctl_in.dir == DIR_LEFT);
      b_ctl_in.fix   = (b_ctl_in.dir != DIR_NONE) && (cfg.isum != '0);
      depth = b_ctl_in.yaxis ? a_ovy_ff : a_ovx_ff;
      ds    = $signed({1'b0, depth}) - $signed({7'b0, cfg.slop});
      b_dd_in = (!b_ctl_in.fix || ds[31]) ? '0 : ds[30:0];
      dsel  = b_ctl_in.yaxis ? a_dvy_ff : a_dvx_ff;
      nrvs  = b_ctl_in.neg ? $signed({dsel[32], dsel}) : -$signed({dsel[32], dsel});
      // Only an approaching pair gets an impulse; a zero speed gives none.
      b_nrv_in = (b_ctl_in.fix && !nrvs[33]) ? nrvs[32:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_box_ff <= in_data.box;
         a_hit_ff <= a_hit_in;
         a_ovx_ff <= a_ovx_in;
         a_ovy_ff <= a_ovy_in;
         a_xlt_ff <= a_xlt_in;
         a_xgt_ff <= a_xgt_in;
         a_ylt_ff <= a_ylt_in;
         a_ygt_ff <= a_ygt_in;
         a_dvx_ff <= a_dvx_in;
         a_dvy_ff <= a_dvy_in;
      end
      if (en_b) begin
         b_box_ff <= a_box_ff;
         b_ctl_ff <= b_ctl_in;
         b_dd_ff  <= b_dd_in;
         b_nrv_ff <= b_nrv_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_box   = b_box_ff;
   assign out_ctl   = b_ctl_ff;
   assign out_dd    = b_dd_ff;
   assign out_nrv   = b_nrv_ff;

endmodule

// ===== hdl/acr_scale.sv =====
// Scaling stages: percent and restitution products, then the dividends.
// Two register stages. Depends on acr_pkg.
module acr_scale import acr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  acr_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  acr_box_type       in_box,
   input  acr_ctl_type       in_ctl,
   input  logic [DD_W-1:0]   in_dd,
   input  logic [NRV_W-1:0]  in_nrv,
   output logic              out_valid,
   input  logic              out_ready,
   output acr_num_type       out_side,
   output logic [NUM_W-1:0]  out_nt,
   output logic [NUM_W-1:0]  out_nk
);

   logic              c_v_ff, c_v_in, en_c;
   acr_box_type       c_box_ff;
   acr_ctl_type       c_ctl_ff;
   logic [47:0]       c_tp_ff, c_tp_in;
   logic [50:0]       c_kp_ff, c_kp_in;

   logic              d_v_ff, d_v_in, en_d;
   acr_num_type       d_side_ff, d_side_in;
   logic [NUM_W-1:0]  d_nt_ff, d_nt_in, d_nk_ff, d_nk_in;
   logic [56:0]       nt_w;
   logic [58:0]       nk_w;

   assign en_d     = !d_v_ff || out_ready;
   assign en_c     = !c_v_ff || en_d;
   assign in_ready = en_c;
   assign c_v_in   = en_c ? in_valid : c_v_ff;
   assign d_v_in   = en_d ? c_v_ff : d_v_ff;

   assign c_tp_in = {17'b0, in_dd} * {31'b0, cfg.pct};
   assign c_kp_in = {18'b0, in_nrv} * {33'b0, cfg.rfac};

   always_comb begin
      d_side_in.box = c_box_ff;
      d_side_in.ctl = c_ctl_ff;
      d_side_in.t   = c_tp_ff[47:16];
      d_side_in.k   = c_kp_ff[49:16];
      nt_w    = 57'(d_side_in.t) * 57'(cfg.mim);
      nk_w    = 59'(d_side_in.k) * 59'(cfg.mim);
      d_nt_in = NUM_W'(nt_w);
      d_nk_in = NUM_W'(nk_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         c_v_ff <= c_v_in;
         d_v_ff <= d_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_box_ff <= in_box;
         c_ctl_ff <= in_ctl;
         c_tp_ff  <= c_tp_in;
         c_kp_ff  <= c_kp_in;
      end
      if (en_d) begin
         d_side_ff <= d_side_in;
         d_nt_ff   <= d_nt_in;
         d_nk_ff   <= d_nk_in;
      end
   end

   assign out_valid = d_v_ff;
   assign out_side  = d_side_ff;
   assign out_nt    = d_nt_ff;
   assign out_nk    = d_nk_ff;

endmodule

// ===== hdl/acr_div.sv =====
// Pipelined restoring divider, two lanes in lockstep, by the inverse-mass sum.
// STEP_BITS quotient bits per stage. Depends on acr_pkg.
module acr_div import acr_pkg::*; #(
   parameter int STEP_BITS = DIV_STEP_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  acr_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  acr_num_type       in_side,
   input  logic [NUM_W-1:0]  in_nt,
   input  logic [NUM_W-1:0]  in_nk,
   output logic              out_valid,
   input  logic              out_ready,
   output acr_num_type       out_side,
   output logic [QUO_W-1:0]  out_qt,
   output logic [SUM_W-1:0]  out_rt,
   output logic [QUO_W-1:0]  out_qk,
   output logic [SUM_W-1:0]  out_rk
);

   localparam int NST = (QUO_W + STEP_BITS - 1) / STEP_BITS;
   localparam int QP  = NST * STEP_BITS;
   localparam int EXT = QP + SUM_W;

   logic              v_ff [NST];
   logic              v_in [NST];
   logic [NST:0]      en;
   acr_num_type       side_ff [NST];
   logic [SUM_W-1:0]  rem_ff [NST][2];
   logic [SUM_W-1:0]  rem_in [NST][2];
   logic [QP-1:0]     low_ff [NST][2];
   logic [QP-1:0]     low_in [NST][2];
   logic [EXT-1:0]    ext [2];
   logic [SUM_W:0]    r2;
   logic [SUM_W-1:0]  r;
   logic [QP-1:0]     l;
   logic              ge;

   assign ext[0] = EXT'(in_nt);
   assign ext[1] = EXT'(in_nk);

   always_comb begin
      en[NST] = out_ready;
      for (int s = NST - 1; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   // Each stage shifts STEP_BITS dividend bits into the partial remainder.
   always_comb begin
      r2 = '0;
      r  = '0;
      l  = '0;
      ge = 1'b0;
      for (int s = 0; s < NST; s++) begin
         v_in[s] = en[s] ? ((s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s - 1]) : v_ff[s];
         for (int ln = 0; ln < 2; ln++) begin
            if (s == 0) begin
               r = ext[ln][EXT-1:QP];
               l = ext[ln][QP-1:0];
            end else begin
               r = rem_ff[(s == 0) ? 0 : s - 1][ln];
               l = low_ff[(s == 0) ? 0 : s - 1][ln];
            end
            for (int j = 0; j < STEP_BITS; j++) begin
               r2 = {r, l[QP-1]};
               ge = r2 >= {1'b0, cfg.isum};
               l  = {l[QP-2:0], ge};
               r  = ge ? SUM_W'(r2 - {1'b0, cfg.isum}) : r2[SUM_W-1:0];
            end
            rem_in[s][ln] = r;
            low_in[s][ln] = l;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) v_ff[s] <= 1'b0;
      end else begin
         for (int s = 0; s < NST; s++) v_ff[s] <= v_in[s];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (en[s]) begin
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s - 1];
            for (int ln = 0; ln < 2; ln++) begin
               rem_ff[s][ln] <= rem_in[s][ln];
               low_ff[s][ln] <= low_in[s][ln];
            end
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_side  = side_ff[NST-1];
   assign out_qt    = low_ff[NST-1][0][QUO_W-1:0];
   assign out_rt    = rem_ff[NST-1][0];
   assign out_qk    = low_ff[NST-1][1][QUO_W-1:0];
   assign out_rk    = rem_ff[NST-1][1];

endmodule

// ===== hdl/acr_apply.sv =====
// Back end of the resolver: block shares from the quotients, signed updates,
// saturation and the result register. Depends on acr_pkg.
module acr_apply import acr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  acr_num_type       in_side,
   input  logic [QUO_W-1:0]  in_qt,
   input  logic [SUM_W-1:0]  in_rt,
   input  logic [QUO_W-1:0]  in_qk,
   input  logic [SUM_W-1:0]  in_rk,
   output logic              out_valid,
   input  logic              out_ready,
   output acr_rsp_type       out_data
);

   logic                    e_v_ff, e_v_in, en_e;
   acr_box_type             e_box_ff;
   acr_ctl_type             e_ctl_ff;
   logic signed [DLT_W-1:0] e_mp_ff, e_mp_in, e_bp_ff, e_bp_in;
   logic signed [DLT_W-1:0] e_mv_ff, e_mv_in, e_bv_ff, e_bv_in;

   logic                    f_v_ff, f_v_in, en_f;
   acr_rsp_type             f_rsp_ff, f_rsp_in;

   logic [QUO_W-1:0]        pb, dvb;

   function automatic logic signed [DLT_W-1:0] sdelta(input logic [QUO_W-1:0] mag,
                                                       input logic negate);
      logic signed [DLT_W-1:0] m;
      m = $signed({2'b00, mag});
      return negate ? -m : m;
   endfunction

   function automatic logic [31:0] adj(input logic signed [31:0] v,
                                       input logic signed [DLT_W-1:0] d,
                                       input logic on);
      logic signed [36:0] s;
      s = $signed({{5{v[31]}}, v}) + (on ? $signed({d[DLT_W-1], d}) : 37'sd0);
      if (s > 37'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -37'sd2147483648) return 32'h8000_0000;
      return s[31:0];
   endfunction

   assign en_f     = !f_v_ff || out_ready;
   assign en_e     = !e_v_ff || en_f;
   assign in_ready = en_e;
   assign e_v_in   = en_e ? in_valid : e_v_ff;
   assign f_v_in   = en_f ? e_v_ff : f_v_ff;

   // The block share is the total less the mover share rounded up, so it is floored too.
   always_comb begin
      pb  = QUO_W'({2'b00, in_side.t}) - in_qt - QUO_W'(|in_rt);
      dvb = in_side.k - in_qk - QUO_W'(|in_rk);
      e_mp_in = in_side.ctl.fix ? sdelta(in_qt, in_side.ctl.neg) : '0;
      e_bp_in = in_side.ctl.fix ? sdelta(pb, !in_side.ctl.neg) : '0;
      e_mv_in = in_side.ctl.fix ? sdelta(in_qk, in_side.ctl.neg) : '0;
      e_bv_in = in_side.ctl.fix ? sdelta(dvb, !in_side.ctl.neg) : '0;
   end

   always_comb begin
      f_rsp_in.hit      = e_ctl_ff.hit;
      f_rsp_in.dir      = e_ctl_ff.dir;
      f_rsp_in.on_block = e_ctl_ff.dir == DIR_UP;
      f_rsp_in.box.mx   = adj(e_box_ff.mx,  e_mp_ff, !e_ctl_ff.yaxis);
      f_rsp_in.box.my   = adj(e_box_ff.my,  e_mp_ff,  e_ctl_ff.yaxis);
      f_rsp_in.box.mvx  = adj(e_box_ff.mvx, e_mv_ff, !e_ctl_ff.yaxis);
      f_rsp_in.box.mvy  = adj(e_box_ff.mvy, e_mv_ff,  e_ctl_ff.yaxis);
      f_rsp_in.box.bx   = adj(e_box_ff.bx,  e_bp_ff, !e_ctl_ff.yaxis);
      f_rsp_in.box.by   = adj(e_box_ff.by,  e_bp_ff,  e_ctl_ff.yaxis);
      f_rsp_in.box.bvx  = adj(e_box_ff.bvx, e_bv_ff, !e_ctl_ff.yaxis);
      f_rsp_in.box.bvy  = adj(e_box_ff.bvy, e_bv_ff,  e_ctl_ff.yaxis);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         e_v_ff <= e_v_in;
         f_v_ff <= f_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_box_ff <= in_side.box;
         e_ctl_ff <= in_side.ctl;
         e_mp_ff  <= e_mp_in;
         e_bp_ff  <= e_bp_in;
         e_mv_ff  <= e_mv_in;
         e_bv_ff  <= e_bv_in;
      end
      if (en_f) f_rsp_ff <= f_rsp_in;
   end

   assign out_valid = f_v_ff;
   assign out_data  = f_rsp_ff;

endmodule

// ===== hdl/aabb_collision_resolve_unit.sv =====
// Resolves one mover/block pair of axis-aligned boxes per clock while the
// response side is not stalled. A request carries both boxes (corner, size,
// velocity, Q16.16); the response carries the hit flag, the contact normal,
// the landed-on-top flag and the eight corrected positions and velocities,
// saturated to 32 bits. The unit is a fully pipelined datapath: it takes a
// new request every cycle while the response side is not stalled. The divider
// by the inverse-mass sum resolves DIV_STEP_BITS quotient bits per stage.
// Each stage holds its data while the stage after it is full, so a stalled
// response side fills the empty stages before the request side is held off.
// Configuration registers are written through the csr channel, which is
// always ready; they must only be changed while no request is in flight.
`include "aabb_collision_resolve_unit_macros.svh"

module aabb_collision_resolve_unit import acr_pkg::*; #(
   parameter int DIV_STEP_BITS = DIV_STEP_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // From bit 0: mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
   // block_x, block_y, block_w, block_h, block_vx, block_vy, zero padding.
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // Response channel.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // From bit 0: hit, contact_dir, on_block, out_mover_x, out_mover_y,
   // out_mover_vx, out_mover_vy, out_block_x, out_block_y, out_block_vx,
   // out_block_vy, zero padding.
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration write channel.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic [MASS_W-1:0] mim_ff, mim_in, bim_ff, bim_in, slop_ff, slop_in;
   logic [FRAC_W-1:0] mres_ff, mres_in, bres_ff, bres_in, pct_ff, pct_in;
   logic              csr_wr;
   acr_cfg_type       cfg;
   acr_req_type       req_data;

   logic              f_valid, f_ready;
   acr_box_type       f_box;
   acr_ctl_type       f_ctl;
   logic [DD_W-1:0]   f_dd;
   logic [NRV_W-1:0]  f_nrv;

   logic              s_valid, s_ready;
   acr_num_type       s_side;
   logic [NUM_W-1:0]  s_nt, s_nk;

   logic              d_valid, d_ready;
   acr_num_type       d_side;
   logic [QUO_W-1:0]  d_qt, d_qk;
   logic [SUM_W-1:0]  d_rt, d_rk;

   acr_rsp_type       rsp_data;

   // Configuration registers; writes beyond the register list are dropped.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      mim_in  = mim_ff;
      bim_in  = bim_ff;
      mres_in = mres_ff;
      bres_in = bres_ff;
      slop_in = slop_ff;
      pct_in  = pct_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_MOVER_INV_MASS:     mim_in  = csr_data[MASS_W-1:0];
            CSR_BLOCK_INV_MASS:     bim_in  = csr_data[MASS_W-1:0];
            CSR_MOVER_RESTITUTION:  mres_in = csr_data[FRAC_W-1:0];
            CSR_BLOCK_RESTITUTION:  bres_in = csr_data[FRAC_W-1:0];
            CSR_CORRECTION_SLOP:    slop_in = csr_data[MASS_W-1:0];
            CSR_CORRECTION_PERCENT: pct_in  = csr_data[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mim_ff  <= MOVER_INV_MASS_RST;
         bim_ff  <= BLOCK_INV_MASS_RST;
         mres_ff <= MOVER_RESTITUTION_RST;
         bres_ff <= BLOCK_RESTITUTION_RST;
         slop_ff <= CORRECTION_SLOP_RST;
         pct_ff  <= CORRECTION_PERCENT_RST;
      end else begin
         mim_ff  <= mim_in;
         bim_ff  <= bim_in;
         mres_ff <= mres_in;
         bres_ff <= bres_in;
         slop_ff <= slop_in;
         pct_ff  <= pct_in;
      end
   end

   // Derived settings feed the pipeline directly; the user must keep them static
   // while requests are in flight, as the block does not enforce it. They are the
   // inverse-mass sum and the restitution factor 1 + min(e_mover, e_block).
   always_comb begin
      cfg.mim  = mim_ff;
      cfg.bim  = bim_ff;
      cfg.isum = {1'b0, mim_ff} + {1'b0, bim_ff};
      cfg.rfac = RFAC_ONE + {1'b0, ((mres_ff < bres_ff) ? mres_ff : bres_ff)};
      cfg.slop = slop_ff;
      cfg.pct  = pct_ff;
   end

   // Request unpacking, lowest field first.
   always_comb begin
      req_data.box.mx  = req_tdata[31:0];
      req_data.box.my  = req_tdata[63:32];
      req_data.mw      = req_tdata[94:64];
      req_data.mh      = req_tdata[125:95];
      req_data.box.mvx = req_tdata[157:126];
      req_data.box.mvy = req_tdata[189:158];
      req_data.box.bx  = req_tdata[221:190];
      req_data.box.by  = req_tdata[253:222];
      req_data.bw      = req_tdata[284:254];
      req_data.bh      = req_tdata[315:285];
      req_data.box.bvx = req_tdata[347:316];
      req_data.box.bvy = req_tdata[379:348];
   end

   // Overlap test, normal choice, penetration beyond slop, closing speed.
   acr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_box   (f_box),
      .out_ctl   (f_ctl),
      .out_dd    (f_dd),
      .out_nrv   (f_nrv)
   );

   // Correction and impulse magnitudes, and the mover-share dividends.
   acr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_box    (f_box),
      .in_ctl    (f_ctl),
      .in_dd     (f_dd),
      .in_nrv    (f_nrv),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_side  (s_side),
      .out_nt    (s_nt),
      .out_nk    (s_nk)
   );

   // Mover shares: floor(t * m / S) and floor(k * m / S) with remainders.
   acr_div #(
      .STEP_BITS (DIV_STEP_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_side   (s_side),
      .in_nt     (s_nt),
      .in_nk     (s_nk),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_side  (d_side),
      .out_qt    (d_qt),
      .out_rt    (d_rt),
      .out_qk    (d_qk),
      .out_rk    (d_rk)
   );

   // Block shares, signed updates along the normal, saturation.
   acr_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_side   (d_side),
      .in_qt     (d_qt),
      .in_rt     (d_rt),
      .in_qk     (d_qk),
      .in_rk     (d_rk),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {3'b000,
                       rsp_data.box.bvy, rsp_data.box.bvx,
                       rsp_data.box.by,  rsp_data.box.bx,
                       rsp_data.box.mvy, rsp_data.box.mvx,
                       rsp_data.box.my,  rsp_data.box.mx,
                       rsp_data.on_block, rsp_data.dir, rsp_data.hit};

   `ACR_ASSERT_IMP(a_dir_needs_hit, clock, reset,
                   rsp_tvalid && (rsp_data.dir != DIR_NONE), rsp_data.hit,
                   "contact normal reported without a hit")
   `ACR_ASSERT_IMP(a_on_block_is_up, clock, reset,
                   rsp_tvalid, rsp_data.on_block == (rsp_data.dir == DIR_UP),
                   "on_block disagrees with the contact normal")
   `ACR_ASSERT_IMP(a_ready_after_reset, clock, reset,
                   $past(reset), req_tready,
                   "empty pipeline refuses a request after reset")
   `ACR_ASSERT_NXT(a_csr_restitution_write, clock, reset,
                   csr_valid && (csr_index == CSR_MOVER_RESTITUTION),
                   mres_ff == $past(csr_data[FRAC_W-1:0]),
                   "restitution write did not land")

endmodule
